/* design/tmb_pkg.sv */
// tmb_pkg: types and codes shared by the typed mutex bank.
// Depends on nothing; every other design file but tmb_ram imports it.
package tmb_pkg;

  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int THREAD_W = 8;
  localparam int TYPE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 16;
  localparam int LSTATE_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOCK    = 2'd0,
    KIND_TRYLOCK = 2'd1,
    KIND_UNLOCK  = 2'd2,
    KIND_INIT    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_DEADLOCK = 3'd2,
    ST_NOPERM   = 3'd3,
    ST_WAIT     = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // Stored lock state and mutex type keep raw codes: a type of three is
  // never written but is still decoded (as normal).
  typedef logic [LSTATE_W-1:0] lstate_t;
  localparam lstate_t LS_UNLOCKED  = 2'd0;
  localparam lstate_t LS_LOCKED    = 2'd1;
  localparam lstate_t LS_CONTESTED = 2'd2;

  typedef logic [TYPE_W-1:0] mtype_t;
  localparam mtype_t TY_NORMAL     = 2'd0;
  localparam mtype_t TY_RECURSIVE  = 2'd1;
  localparam mtype_t TY_ERRORCHECK = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    lstate_t                   lock_state;
    mtype_t                    mutex_type;
    logic [THREAD_W-1:0]       owner_thread;
    logic [COUNT_W-1:0]        nest_count;
    logic                      queue_made;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    kind_t                kind;
    logic [INDEX_W-1:0]   mutex_index;
    logic [THREAD_W-1:0]  thread_id;
    logic [TYPE_W-1:0]    new_type;
  } req_t;

  typedef struct packed {
    status_t status;
    logic    wake;
  } verdict_t;

endpackage

/* design/tmb_req_if.sv */
// tmb_req_if: request channel of the typed mutex bank (valid/ready + payload).
// Depends on tmb_pkg for the field widths.
interface tmb_req_if;
  import tmb_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [INDEX_W-1:0]  mutex_index;
  logic [THREAD_W-1:0] thread_id;
  logic [TYPE_W-1:0]   new_type;

  modport source (output valid, kind, mutex_index, thread_id, new_type, input ready);
  modport sink   (input valid, kind, mutex_index, thread_id, new_type, output ready);
endinterface

/* design/tmb_rsp_if.sv */
// tmb_rsp_if: response channel of the typed mutex bank (valid/ready + payload).
// Depends on tmb_pkg for the field widths.
interface tmb_rsp_if;
  import tmb_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                wake_waiter;

  modport source (output valid, status, wake_waiter, input ready);
  modport sink   (input valid, status, wake_waiter, output ready);
endinterface

/* design/tmb_ram.sv */
// tmb_ram: generic single-write, single-read RAM with a registered read.
// Self-contained; no package needed.
module tmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/tmb_rule.sv */
// tmb_rule: decides status, wake and the new entry of one mutex operation.
// Depends on tmb_pkg (entry, request and verdict types, codes).
module tmb_rule (
  input  tmb_pkg::req_t     req,
  input  tmb_pkg::entry_t   cur,
  input  logic              idx_ok,
  output tmb_pkg::entry_t   nxt,
  output logic              we,
  output tmb_pkg::verdict_t verdict
);
  import tmb_pkg::*;

  logic is_rec;
  logic is_err;
  logic mine;
  logic at_max;

  assign is_rec = (cur.mutex_type == TY_RECURSIVE);
  assign is_err = (cur.mutex_type == TY_ERRORCHECK);
  assign mine   = (cur.lock_state != LS_UNLOCKED) && (cur.owner_thread == req.thread_id);
  assign at_max = (cur.nest_count == COUNT_MAX);

  always_comb begin
    nxt            = cur;
    we             = idx_ok;
    verdict.status = ST_OK;
    verdict.wake   = 1'b0;

    priority if (!idx_ok) begin
      verdict.status = ST_NOPERM;
    end else if (req.kind == KIND_INIT) begin
      if (req.new_type > TY_ERRORCHECK) begin
        verdict.status = ST_NOPERM;
      end else begin
        nxt.lock_state   = LS_UNLOCKED;
        nxt.owner_thread = '0;
        nxt.nest_count   = '0;
        nxt.queue_made   = 1'b0;
        nxt.mutex_type   = req.new_type;
      end
    end else if (req.thread_id == '0) begin
      verdict.status = ST_NOPERM;
    end else if (req.kind == KIND_LOCK) begin
      priority if (is_rec && mine) begin
        if (at_max) verdict.status = ST_OVERFLOW;
        else nxt.nest_count = cur.nest_count + COUNT_W'(1);
      end else if (is_err && mine) begin
        verdict.status = ST_DEADLOCK;
      end else if (cur.lock_state == LS_UNLOCKED) begin
        nxt.lock_state   = LS_LOCKED;
        nxt.owner_thread = req.thread_id;
        nxt.nest_count   = COUNT_W'(1);
      end else begin
        nxt.queue_made = 1'b1;
        nxt.lock_state = LS_CONTESTED;
        verdict.status = ST_WAIT;
      end
    end else if (req.kind == KIND_TRYLOCK) begin
      priority if (is_rec && mine) begin
        if (at_max) verdict.status = ST_OVERFLOW;
        else nxt.nest_count = cur.nest_count + COUNT_W'(1);
      end else if (cur.lock_state == LS_UNLOCKED) begin
        nxt.lock_state   = LS_LOCKED;
        nxt.owner_thread = req.thread_id;
        nxt.nest_count   = COUNT_W'(1);
      end else begin
        verdict.status = ST_BUSY;
      end
    end else begin
      // unlock
      priority if ((is_rec || is_err) && !mine) begin
        verdict.status = ST_NOPERM;
      end else if (is_rec && (cur.nest_count > COUNT_W'(1))) begin
        nxt.nest_count = cur.nest_count - COUNT_W'(1);
      end else begin
        verdict.wake     = (cur.lock_state == LS_CONTESTED) && cur.queue_made;
        nxt.lock_state   = LS_UNLOCKED;
        nxt.owner_thread = '0;
        nxt.nest_count   = '0;
      end
    end
  end

endmodule

/* design/typed_mutex_bank.sv */
// typed_mutex_bank: top level of a bank of typed mutexes held in one RAM.
// Depends on tmb_pkg, tmb_req_if, tmb_rsp_if, tmb_ram and tmb_rule.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------
//  req     | in  | kind, mutex_index, thread_id, new_type
//  rsp     | out | status, wake_waiter
//
// Each request is accepted in S_IDLE, where the accept edge issues the RAM
// read; S_LOOK then decides on the registered read data and writes the entry
// back while loading the response register. One request is in flight at a
// time, so accesses to the same entry never overlap. After rst the block
// sweeps every RAM entry to its reset contents with req.ready low. A response that is not
// taken stays in its register and holds the decision cycle until it leaves.
module typed_mutex_bank #(
  parameter int MUTEX_COUNT = 16
) (
  input logic     clk,
  input logic     rst,
  tmb_req_if.sink   req,
  tmb_rsp_if.source rsp
);
  import tmb_pkg::*;

  localparam int AW  = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  // index wide enough for both the port field and a RAM address
  localparam int IXW = (AW > INDEX_W) ? AW : INDEX_W;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  req_t            req_q;
  logic            rsp_valid;
  status_t         rsp_status;
  logic            rsp_wake;

  logic            accept;
  logic            rsp_free;
  logic            clr_last;
  logic [IXW-1:0]  in_idx;
  logic [IXW-1:0]  q_idx;
  logic            idx_ok;

  entry_t          cur;
  entry_t          nxt;
  logic            rule_we;
  verdict_t        verdict;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign clr_last  = (clr_addr == AW'(MUTEX_COUNT - 1));

  assign in_idx = IXW'(req.mutex_index);
  assign q_idx  = IXW'(req_q.mutex_index);
  assign idx_ok = (q_idx < MUTEX_COUNT);

  // Sweep writes the reset entry; otherwise write back the decided entry.
  assign ram_we    = (state == S_CLEAR) || ((state == S_LOOK) && rsp_free && rule_we);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : q_idx[AW-1:0];
  assign ram_wdata = (state == S_CLEAR) ? entry_t'('0) : nxt;

  tmb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MUTEX_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_idx[AW-1:0]),
    .rdata (cur)
  );

  tmb_rule u_rule (
    .req     (req_q),
    .cur     (cur),
    .idx_ok  (idx_ok),
    .nxt     (nxt),
    .we      (rule_we),
    .verdict (verdict)
  );

  // Hold the request beat for the decision cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= '{kind:        kind_t'(req.kind),
                 mutex_index: req.mutex_index,
                 thread_id:   req.thread_id,
                 new_type:    req.new_type};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // load a response beat with the decision; drop it once taken
      if ((state == S_LOOK) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state <= S_LOOK;
        end
        S_LOOK: begin
          // advance only when the response register can take the result
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Response payload: load with the decision, hold while stalled.
  always_ff @(posedge clk) begin
    if ((state == S_LOOK) && rsp_free) begin
      rsp_status <= verdict.status;
      rsp_wake   <= verdict.wake;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.wake_waiter = rsp_wake;

endmodule

/* design/tmb_checker.sv */
// tmb_checker: port-level checks on typed_mutex_bank, with its bind.
// Depends on tmb_pkg for the status codes.
module tmb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [tmb_pkg::STATUS_W-1:0]  rsp_status,
  input logic                          rsp_wake
);
  import tmb_pkg::*;

  // No response survives a reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // One request in flight: no accept directly after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while one is in flight");

  // A wake is only ever reported with a successful unlock.
  a_wake_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_wake) |-> (rsp_status == ST_OK))
    else $error("wake_waiter with non-ok status");

  // Stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_wake)))
    else $error("stalled response changed");

endmodule

bind typed_mutex_bank tmb_checker u_tmb_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_wake   (rsp.wake_waiter)
);
